// File: sv/pqe_pkg.sv
// ----------------------------------------------------------------------------
// pqe_pkg
// Shared types and constants of the P-square quantile estimator.
// ----------------------------------------------------------------------------
package pqe_pkg;

  localparam int HEIGHT_W   = 48;
  localparam int POS_W      = 32;
  localparam int QP_W       = 16;
  localparam int MD_X_W     = 34;
  localparam int MD_Z_W     = 34;
  localparam int MD_PROD_W  = MD_X_W + HEIGHT_W;

  localparam int DEF_SAMPLE_BITS   = 32;
  localparam int DEF_FRACTION_BITS = 16;
  localparam logic [QP_W-1:0] QP_RESET = 16'd32768;

  typedef enum logic [1:0] {
    MD_IDLE,
    MD_MUL,
    MD_DIV,
    MD_DONE
  } md_state_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOAD,
    ST_SORT,
    ST_EVAL,
    ST_START,
    ST_WAIT,
    ST_CAND,
    ST_DONE
  } pqe_state_e;

  typedef enum logic [2:0] {
    OP_T1,
    OP_S1,
    OP_T2,
    OP_S2,
    OP_LIN
  } pqe_op_e;

  typedef struct packed {
    logic                start;
    logic [MD_X_W-1:0]   x;
    logic [HEIGHT_W-1:0] y;
    logic [MD_Z_W-1:0]   z;
  } md_req_t;

  typedef struct packed {
    logic                done;
    logic [HEIGHT_W-1:0] q;
  } md_rsp_t;

endpackage

// File: sv/pqe_muldiv.sv
// ----------------------------------------------------------------------------
// pqe_muldiv
// Shared iterative unit computing floor(x*y/z): shift-add multiply, then
// restoring division, one bit per cycle.
// ----------------------------------------------------------------------------
module pqe_muldiv (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  pqe_pkg::md_req_t req_i,
  output pqe_pkg::md_rsp_t rsp_o
);
  import pqe_pkg::*;

  localparam int CNT_W = $clog2(MD_PROD_W);

  md_state_e state_q, state_d;
  logic [CNT_W-1:0]     cnt_q;
  logic [MD_PROD_W-1:0] acc_q;
  logic [MD_PROD_W-1:0] ys_q;
  logic [MD_X_W-1:0]    xs_q;
  logic [MD_Z_W-1:0]    z_q;
  logic [MD_Z_W-1:0]    rem_q;
  logic [MD_Z_W:0]      rem_sh;
  logic                 ge;

  assign rem_sh = {rem_q, acc_q[MD_PROD_W-1]};
  assign ge     = rem_sh >= {1'b0, z_q};

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      MD_IDLE: if (req_i.start) state_d = MD_MUL;
      MD_MUL:  if (cnt_q == CNT_W'(MD_X_W - 1)) state_d = MD_DIV;
      MD_DIV:  if (cnt_q == CNT_W'(MD_PROD_W - 1)) state_d = MD_DONE;
      MD_DONE: state_d = MD_IDLE;
      default: state_d = MD_IDLE;
    endcase
  end

  always_comb begin
    rsp_o.done = (state_q == MD_DONE);
    rsp_o.q    = acc_q[HEIGHT_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= MD_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      if (state_q != state_d) cnt_q <= '0;
      else cnt_q <= cnt_q + CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      MD_IDLE: begin
        if (req_i.start) begin
          acc_q <= '0;
          ys_q  <= MD_PROD_W'(req_i.y);
          xs_q  <= req_i.x;
          z_q   <= req_i.z;
          rem_q <= '0;
        end
      end
      MD_MUL: begin
        if (xs_q[0]) acc_q <= acc_q + ys_q;
        ys_q <= ys_q << 1;
        xs_q <= xs_q >> 1;
      end
      MD_DIV: begin
        rem_q <= ge ? MD_Z_W'(rem_sh - {1'b0, z_q}) : MD_Z_W'(rem_sh);
        acc_q <= {acc_q[MD_PROD_W-2:0], ge};
      end
      default: ;
    endcase
  end

endmodule

// File: sv/p_square_quantile_estimator_core.sv
// ----------------------------------------------------------------------------
// p_square_quantile_estimator_core
// Streaming P-square estimator of the p-quantile of unsigned samples.
// ----------------------------------------------------------------------------
// Each accepted sample beat yields one result beat carrying the middle,
// lowest and highest marker heights in unsigned fixed point. The first five
// samples fill the markers (the fifth is followed by a sort); the results
// before the fifth carry zeros, and ready_res rises with that fifth result.
// A later sample goes through cell search and bookkeeping and then one
// evaluation for each of markers 1 to 3. A marker that moves then needs four
// or five passes of the shared multiply-divide unit and a check of the
// parabolic height. The input stalls for the whole of that work; a finished
// result sits in the output register and the next sample is taken while it
// waits. The quantile register is only written while the block is idle and
// no sample is offered.
module p_square_quantile_estimator_core #(
  parameter int SAMPLE_BITS   = pqe_pkg::DEF_SAMPLE_BITS,
  parameter int FRACTION_BITS = pqe_pkg::DEF_FRACTION_BITS
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [SAMPLE_BITS-1:0]       sample_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [pqe_pkg::HEIGHT_W-1:0] estimate_o,
  output logic                         ready_res_o,
  output logic [pqe_pkg::HEIGHT_W-1:0] lowest_seen_o,
  output logic [pqe_pkg::HEIGHT_W-1:0] highest_seen_o,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [pqe_pkg::QP_W-1:0]     cfg_data_i
);
  import pqe_pkg::*;

  localparam int HW     = HEIGHT_W;
  localparam int XWIDE  = SAMPLE_BITS + FRACTION_BITS;
  localparam int IW     = QP_W + FRACTION_BITS + 2;
  localparam int DIFF_W = ((POS_W + FRACTION_BITS > HW) ? POS_W + FRACTION_BITS : HW) + 2;
  localparam int CW     = HW + 3;
  localparam logic [HW-1:0] HMAX = {HW{1'b1}};
  localparam logic [HW-1:0] ONE  = HW'(1) << FRACTION_BITS;

  pqe_state_e state_q, state_d;
  pqe_op_e    op_q;

  logic [HW-1:0]    h_q   [5];
  logic [POS_W-1:0] pos_q [5];
  logic [HW-1:0]    des_q [5];
  logic [2:0]       fill_q;
  logic [QP_W-1:0]  qp_q;
  logic [HW-1:0]    x_q;
  logic [2:0]       sort_q;
  logic [1:0]       mk_q;

  // Latched operands of the marker under adjustment.
  logic             up_q;
  logic [POS_W-1:0] a_q, c_q;
  logic [HW-1:0]    ug_q, dg_q;
  logic [HW-1:0]    t_q, s1_q;

  logic              out_valid_q;
  logic              ready_q;
  logic [HW-1:0]     est_q, low_q, high_q;

  md_req_t md_req;
  md_rsp_t md_rsp;

  pqe_muldiv u_muldiv (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (md_req),
    .rsp_o  (md_rsp)
  );

  // Desired positions as loaded from a fresh p.
  function automatic logic [HW-1:0] des_init(input logic [2:0] idx, input logic [QP_W-1:0] qp);
    logic [IW-1:0] wide;
    logic [HW-1:0] two_p, four_p;
    logic [HW-1:0] r;
    wide   = IW'(qp) << FRACTION_BITS;
    two_p  = HW'((wide << 1) >> 16);
    four_p = HW'((wide << 2) >> 16);
    unique case (idx)
      3'd0:    r = ONE;
      3'd1:    r = ONE + two_p;
      3'd2:    r = ONE + four_p;
      3'd3:    r = 3 * ONE + two_p;
      default: r = 5 * ONE;
    endcase
    return r;
  endfunction

  // Sample converted to a saturated height.
  logic [XWIDE-1:0] x_wide;
  logic [HW-1:0]    x_in;
  assign x_wide = XWIDE'(sample_i) << FRACTION_BITS;
  assign x_in   = (x_wide > XWIDE'(HMAX)) ? HMAX : HW'(x_wide);

  // Increments of the desired positions.
  logic [IW-1:0] qp_wide, qp_half;
  logic [HW-1:0] inc [5];
  assign qp_wide = IW'(qp_q) << FRACTION_BITS;
  assign qp_half = (IW'(qp_q) + IW'(17'd65536)) << FRACTION_BITS;
  assign inc[0]  = '0;
  assign inc[1]  = HW'(qp_wide >> 17);
  assign inc[2]  = HW'(qp_wide >> 16);
  assign inc[3]  = HW'(qp_half >> 17);
  assign inc[4]  = ONE;

  // Cell of the incoming sample.
  logic [2:0] seg;
  always_comb begin
    if (x_q > h_q[2]) seg = (x_q < h_q[3]) ? 3'd2 : 3'd3;
    else seg = (x_q >= h_q[1]) ? 3'd1 : 3'd0;
  end

  // Evaluation of the marker mk_q against its neighbours.
  logic [2:0]              im, il, ih;
  logic signed [POS_W:0]   a_s, c_s;
  logic signed [DIFF_W-1:0] diff;
  logic                    mv_up, mv_dn, go;
  assign im    = {1'b0, mk_q};
  assign il    = im - 3'd1;
  assign ih    = im + 3'd1;
  assign a_s   = $signed({1'b0, pos_q[im]}) - $signed({1'b0, pos_q[il]});
  assign c_s   = $signed({1'b0, pos_q[ih]}) - $signed({1'b0, pos_q[im]});
  assign diff  = $signed(DIFF_W'(des_q[im]) - (DIFF_W'(pos_q[im]) << FRACTION_BITS));
  assign mv_up = (diff >= $signed(DIFF_W'(ONE))) && (c_s > 1);
  assign mv_dn = (diff <= -$signed(DIFF_W'(ONE))) && (a_s > 1);
  assign go    = (mv_up || mv_dn) && (a_s >= 1) && (c_s >= 1);

  // Parabolic candidate.
  logic [HW:0]          s_sum;
  logic signed [CW-1:0] cand, lo_s, hi_s;
  logic                 in_br;
  assign s_sum = {1'b0, s1_q} + {1'b0, t_q};
  assign lo_s  = $signed(CW'(h_q[il]));
  assign hi_s  = $signed(CW'(h_q[ih]));
  assign cand  = up_q ? $signed(CW'(h_q[im]) + CW'(s_sum))
                      : $signed(CW'(h_q[im]) - CW'(s_sum));
  assign in_br = (cand > lo_s) && (cand < hi_s);

  logic last_mk;
  assign last_mk = (mk_q == 2'd3);

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (in_valid_i) state_d = ST_LOAD;
      ST_LOAD: begin
        if (fill_q < 3'd5) state_d = (fill_q == 3'd4) ? ST_SORT : ST_DONE;
        else state_d = ST_EVAL;
      end
      ST_SORT:  if (sort_q == 3'd4) state_d = ST_DONE;
      ST_EVAL: begin
        if (go) state_d = ST_START;
        else if (last_mk) state_d = ST_DONE;
      end
      ST_START: state_d = ST_WAIT;
      ST_WAIT: begin
        if (md_rsp.done) begin
          if (op_q == OP_S2) state_d = ST_CAND;
          else if (op_q == OP_LIN) state_d = last_mk ? ST_DONE : ST_EVAL;
          else state_d = ST_START;
        end
      end
      ST_CAND: begin
        if (in_br) state_d = last_mk ? ST_DONE : ST_EVAL;
        else state_d = ST_START;
      end
      ST_DONE:  if (!(out_valid_q && out_stall_i)) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // Requests to the shared unit.
  always_comb begin
    md_req.start = (state_q == ST_START);
    md_req.x     = MD_X_W'(1);
    md_req.y     = t_q;
    md_req.z     = MD_Z_W'(c_q);
    unique case (op_q)
      OP_T1: begin
        md_req.x = up_q ? MD_X_W'(a_q) + MD_X_W'(1) : MD_X_W'(a_q) - MD_X_W'(1);
        md_req.y = ug_q;
        md_req.z = MD_Z_W'(a_q) + MD_Z_W'(c_q);
      end
      OP_S1: ;
      OP_T2: begin
        md_req.x = up_q ? MD_X_W'(c_q) - MD_X_W'(1) : MD_X_W'(c_q) + MD_X_W'(1);
        md_req.y = dg_q;
        md_req.z = MD_Z_W'(a_q) + MD_Z_W'(c_q);
      end
      OP_S2:  md_req.z = MD_Z_W'(a_q);
      OP_LIN: begin
        md_req.y = up_q ? ug_q : dg_q;
        md_req.z = up_q ? MD_Z_W'(c_q) : MD_Z_W'(a_q);
      end
      default: ;
    endcase
  end

  assign in_stall_o     = (state_q != ST_IDLE);
  assign cfg_ready_o    = (state_q == ST_IDLE) && !in_valid_i;
  assign out_valid_o    = out_valid_q;
  assign estimate_o     = est_q;
  assign ready_res_o    = ready_q;
  assign lowest_seen_o  = low_q;
  assign highest_seen_o = high_q;

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      fill_q      <= '0;
      qp_q        <= QP_RESET;
      out_valid_q <= 1'b0;
      sort_q      <= '0;
      mk_q        <= 2'd1;
      op_q        <= OP_T1;
      for (int i = 0; i < 5; i++) begin
        pos_q[i] <= POS_W'(i + 1);
        des_q[i] <= des_init(3'(i), QP_RESET);
      end
    end else begin
      state_q <= state_d;
      if (state_q == ST_DONE && !(out_valid_q && out_stall_i)) out_valid_q <= 1'b1;
      else if (out_valid_q && !out_stall_i) out_valid_q <= 1'b0;
      if (cfg_valid_i && cfg_ready_o) begin
        qp_q <= cfg_data_i;
        if (fill_q < 3'd5) begin
          for (int i = 0; i < 5; i++) des_q[i] <= des_init(3'(i), cfg_data_i);
        end
      end
      unique case (state_q)
        ST_LOAD: begin
          sort_q <= '0;
          mk_q   <= 2'd1;
          if (fill_q < 3'd5) begin
            fill_q <= fill_q + 3'd1;
          end else begin
            for (int i = 1; i < 5; i++) begin
              if (3'(i) > seg && pos_q[i] != {POS_W{1'b1}}) pos_q[i] <= pos_q[i] + POS_W'(1);
            end
            for (int i = 0; i < 5; i++) begin
              des_q[i] <= ({1'b0, des_q[i]} + {1'b0, inc[i]} > {1'b0, HMAX}) ? HMAX
                        : des_q[i] + inc[i];
            end
          end
        end
        ST_SORT: sort_q <= sort_q + 3'd1;
        ST_EVAL: begin
          op_q <= OP_T1;
          if (!go && !last_mk) mk_q <= mk_q + 2'd1;
        end
        ST_WAIT: begin
          if (md_rsp.done) begin
            unique case (op_q)
              OP_T1:   op_q <= OP_S1;
              OP_S1:   op_q <= OP_T2;
              OP_T2:   op_q <= OP_S2;
              OP_S2:   op_q <= OP_S2;
              default: begin
                op_q <= OP_T1;
                pos_q[im] <= up_q ? pos_q[im] + POS_W'(1) : pos_q[im] - POS_W'(1);
                if (!last_mk) mk_q <= mk_q + 2'd1;
              end
            endcase
          end
        end
        ST_CAND: begin
          if (in_br) begin
            pos_q[im] <= up_q ? pos_q[im] + POS_W'(1) : pos_q[im] - POS_W'(1);
            if (!last_mk) mk_q <= mk_q + 2'd1;
          end else begin
            op_q <= OP_LIN;
          end
        end
        default: ;
      endcase
    end
  end

  // Heights and operand registers.
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_IDLE: if (in_valid_i) x_q <= x_in;
      ST_LOAD: begin
        if (fill_q < 3'd5) begin
          h_q[fill_q] <= x_q;
        end else if (x_q > h_q[2]) begin
          if (x_q >= h_q[3] && x_q > h_q[4]) h_q[4] <= x_q;
        end else if (x_q < h_q[0]) begin
          h_q[0] <= x_q;
        end
      end
      ST_SORT: begin
        // Odd-even transposition: five passes order five entries.
        if (!sort_q[0]) begin
          if (h_q[1] < h_q[0]) begin h_q[0] <= h_q[1]; h_q[1] <= h_q[0]; end
          if (h_q[3] < h_q[2]) begin h_q[2] <= h_q[3]; h_q[3] <= h_q[2]; end
        end else begin
          if (h_q[2] < h_q[1]) begin h_q[1] <= h_q[2]; h_q[2] <= h_q[1]; end
          if (h_q[4] < h_q[3]) begin h_q[3] <= h_q[4]; h_q[4] <= h_q[3]; end
        end
      end
      ST_EVAL: begin
        up_q <= mv_up;
        a_q  <= a_s[POS_W-1:0];
        c_q  <= c_s[POS_W-1:0];
        ug_q <= (h_q[ih] > h_q[im]) ? h_q[ih] - h_q[im] : '0;
        dg_q <= (h_q[im] > h_q[il]) ? h_q[im] - h_q[il] : '0;
      end
      ST_WAIT: begin
        if (md_rsp.done) begin
          unique case (op_q)
            OP_S1:   s1_q <= md_rsp.q;
            OP_LIN:  h_q[im] <= up_q ? h_q[im] + md_rsp.q : h_q[im] - md_rsp.q;
            default: t_q <= md_rsp.q;
          endcase
        end
      end
      ST_CAND: if (in_br) h_q[im] <= HW'(cand);
      ST_DONE: begin
        if (!(out_valid_q && out_stall_i)) begin
          ready_q <= (fill_q == 3'd5);
          est_q   <= (fill_q == 3'd5) ? h_q[2] : '0;
          low_q   <= (fill_q == 3'd5) ? h_q[0] : '0;
          high_q  <= (fill_q == 3'd5) ? h_q[4] : '0;
        end
      end
      default: ;
    endcase
  end

endmodule
